// File: design/barometer_compensation_macros.svh
// Assertion helpers shared by the barometer compensation design.
`ifndef BAROMETER_COMPENSATION_MACROS_SVH
`define BAROMETER_COMPENSATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bc_pkg.sv
package bc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAL_A = 2'd0,
    CFG_CAL_B = 2'd1,
    CFG_CAL_C = 2'd2,
    CFG_OSS   = 2'd3
  } cfg_idx_t;

  // Compensation constants.
  localparam int T_OFFSET  = 4000;
  localparam int P_C1      = 3038;
  localparam int P_C2      = -7357;
  localparam int P_C3      = 3791;
  localparam int P_SCALE   = 50000;
  localparam int B4_BIAS   = 32768;
  localparam logic [1:0] OSS_RESET = 2'd3;

  // Larger of two widths, used to size datapaths at elaboration.
  function automatic int wmax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Side data carried through the temperature divider.
  typedef struct packed {
    logic [18:0]        up;
    logic signed [19:0] x1;
    logic               dz;
    logic               neg;
  } d1_side_t;

  // Side data carried through the pressure divider.
  typedef struct packed {
    logic signed [15:0] t;
    logic               err;
    logic               br1;
    logic               neg;
  } d2_side_t;

endpackage

// File: design/bc_div.sv
module bc_div
  import bc_pkg::*;
#(
  parameter int NW = 27,
  parameter int DW = 20,
  parameter int QW = 27,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int CW = wmax(NW, DW + QW) + 1;

  logic [CW-1:0] rem_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          ovf_r  [QW];
  logic          v_r    [QW];

  // Quotient larger than QW bits is flagged at entry.
  logic ovf_in;
  assign ovf_in = CW'(num) >= (CW'(den) << QW);

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [CW-1:0] r_in;
    logic [CW-1:0] dsh;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic          o_in;
    logic          v_in;

    if (j == 0) begin : g_first
      assign r_in = CW'(num);
      assign q_in = '0;
      assign d_in = den;
      assign s_in = side_in;
      assign o_in = ovf_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem_r[j-1];
      assign q_in = q_r[j-1];
      assign d_in = den_r[j-1];
      assign s_in = side_r[j-1];
      assign o_in = ovf_r[j-1];
      assign v_in = v_r[j-1];
    end

    assign dsh = CW'(d_in) << (QW - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= dsh) begin
          rem_r[j] <= r_in - dsh;
          q_r[j]   <= q_in | (QW'(1) << (QW - 1 - j));
        end else begin
          rem_r[j] <= r_in;
          q_r[j]   <= q_in;
        end
        den_r[j]  <= d_in;
        side_r[j] <= s_in;
        ovf_r[j]  <= o_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot      = q_r[QW-1];
  assign ovf       = ovf_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

// File: design/barometer_compensation.sv
// Barometric temperature and pressure compensation. Each item carries a raw
// temperature word and a pressure word already aligned for the oversampling
// setting; the result is temperature in tenths of a degree, pressure in
// pascal and an error flag that is set, with both values zero, when either
// divisor is zero. The pipeline takes one item per clock unless a result is
// held at a stalled output; most of its stages are in the two pipelined
// restoring dividers, 27 stages for the temperature quotient and 33 for the
// pressure quotient, one quotient bit per stage. When a result waits on a
// stalled output, the whole pipeline holds. The user must write calibration
// words through the cfg port only while no item is in flight; the block does not enforce it.
`include "barometer_compensation_macros.svh"

module barometer_compensation
  import bc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_raw_temp,
  input  logic [18:0]        in_raw_press,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_temp_tenths,
  output logic [19:0]        out_pressure_pa,
  output logic               out_div_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Configuration registers.
  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= OSS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_A: cal_a_r <= cfg_data;
        CFG_CAL_B: cal_b_r <= cfg_data;
        CFG_CAL_C: cal_c_r <= cfg_data[31:0];
        CFG_OSS:   oss_r   <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  // Calibration coefficients, unsigned ones widened to signed.
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic signed [16:0] ac4, ac5, ac6;

  assign ac1 = $signed(cal_a_r[63:48]);
  assign ac2 = $signed(cal_a_r[47:32]);
  assign ac3 = $signed(cal_a_r[31:16]);
  assign ac4 = $signed({1'b0, cal_a_r[15:0]});
  assign ac5 = $signed({1'b0, cal_b_r[63:48]});
  assign ac6 = $signed({1'b0, cal_b_r[47:32]});
  assign b1  = $signed(cal_b_r[31:16]);
  assign b2  = $signed(cal_b_r[15:0]);
  assign mc  = $signed(cal_c_r[31:16]);
  assign md  = $signed(cal_c_r[15:0]);

  // The whole pipeline advances unless a finished item is held at the output.
  logic pipe_en;
  assign pipe_en  = !out_valid || !out_stall;
  assign in_stall = !pipe_en;

  // Stage 1: (UT - AC6) * AC5.
  logic               s1_v_r;
  logic signed [34:0] s1_prod_r;
  logic [18:0]        s1_up_r;
  logic signed [17:0] s1_diff;

  assign s1_diff = $signed({2'b0, in_raw_temp}) - 18'(ac6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_prod_r <= 35'(s1_diff) * 35'(ac5);
      s1_up_r   <= in_raw_press;
    end
  end

  // Divider 1 operands: (MC * 2048) / (X1 + MD) on magnitudes.
  logic signed [19:0] s2_x1;
  logic signed [20:0] s2_d;
  logic signed [26:0] s2_n;
  logic [26:0]        d1_num;
  logic [19:0]        d1_den;
  d1_side_t           d1_side_in;
  d1_side_t           d1_side;
  logic [$bits(d1_side_t)-1:0] d1_side_vec;
  logic               d1_valid;
  logic [26:0]        d1_quot;
  logic               d1_ovf;

  assign s2_x1  = 20'(s1_prod_r >>> 15);
  assign s2_d   = 21'(s2_x1) + 21'(md);
  assign s2_n   = $signed({mc, 11'b0});
  assign d1_num = s2_n[26] ? 27'(-s2_n) : 27'(s2_n);
  assign d1_den = s2_d[20] ? 20'(-s2_d) : 20'(s2_d);

  assign d1_side_in.up  = s1_up_r;
  assign d1_side_in.x1  = s2_x1;
  assign d1_side_in.dz  = (s2_d == '0);
  assign d1_side_in.neg = s2_n[26] ^ s2_d[20];

  bc_div #(
    .NW(27),
    .DW(20),
    .QW(27),
    .SW($bits(d1_side_t))
  ) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (s1_v_r),
    .num      (d1_num),
    .den      (d1_den),
    .side_in  (d1_side_in),
    .out_valid(d1_valid),
    .quot     (d1_quot),
    .ovf      (d1_ovf),
    .side_out (d1_side_vec)
  );

  assign d1_side = d1_side_t'(d1_side_vec);

  // Stage 3: B5, temperature and B6.
  logic signed [27:0] s3_x2;
  logic signed [28:0] s3_b5;
  logic signed [29:0] s3_tw;
  logic signed [15:0] s3_t;
  logic               s3_v_r;
  logic signed [29:0] s3_b6_r;
  logic signed [15:0] s3_t_r;
  logic               s3_dz_r;
  logic [18:0]        s3_up_r;

  assign s3_x2 = d1_side.neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
  assign s3_b5 = 29'(d1_side.x1) + 29'(s3_x2);
  assign s3_tw = (30'(s3_b5) + 30'sd8) >>> 4;

  always_comb begin
    if (s3_tw > 30'sd32767) begin
      s3_t = 16'sh7fff;
    end else if (s3_tw < -30'sd32768) begin
      s3_t = 16'sh8000;
    end else begin
      s3_t = 16'(s3_tw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (pipe_en) begin
      s3_v_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_b6_r <= 30'(s3_b5) - 30'(T_OFFSET);
      s3_t_r  <= s3_t;
      s3_dz_r <= d1_side.dz;
      s3_up_r <= d1_side.up;
    end
  end

  // Stage 4: B6 squared and the AC2, AC3 products.
  logic               s4_v_r;
  logic signed [59:0] s4_bb_r;
  logic signed [45:0] s4_ac2b6_r;
  logic signed [45:0] s4_ac3b6_r;
  logic signed [15:0] s4_t_r;
  logic               s4_dz_r;
  logic [18:0]        s4_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (pipe_en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_bb_r    <= 60'(s3_b6_r) * 60'(s3_b6_r);
      s4_ac2b6_r <= 46'(ac2) * 46'(s3_b6_r);
      s4_ac3b6_r <= 46'(ac3) * 46'(s3_b6_r);
      s4_t_r     <= s3_t_r;
      s4_dz_r    <= s3_dz_r;
      s4_up_r    <= s3_up_r;
    end
  end

  // Stage 5: scale the products.
  logic               s5_v_r;
  logic signed [47:0] s5_sq_r;
  logic signed [34:0] s5_x2b_r;
  logic signed [32:0] s5_x1c_r;
  logic signed [15:0] s5_t_r;
  logic               s5_dz_r;
  logic [18:0]        s5_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (pipe_en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s5_sq_r  <= 48'(s4_bb_r >>> 12);
      s5_x2b_r <= 35'(s4_ac2b6_r >>> 11);
      s5_x1c_r <= 33'(s4_ac3b6_r >>> 13);
      s5_t_r   <= s4_t_r;
      s5_dz_r  <= s4_dz_r;
      s5_up_r  <= s4_up_r;
    end
  end

  // Stage 6: B2 and B1 times the scaled square.
  logic               s6_v_r;
  logic signed [63:0] s6_b2sq_r;
  logic signed [63:0] s6_b1sq_r;
  logic signed [34:0] s6_x2b_r;
  logic signed [32:0] s6_x1c_r;
  logic signed [15:0] s6_t_r;
  logic               s6_dz_r;
  logic [18:0]        s6_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (pipe_en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s6_b2sq_r <= 64'(b2) * 64'(s5_sq_r);
      s6_b1sq_r <= 64'(b1) * 64'(s5_sq_r);
      s6_x2b_r  <= s5_x2b_r;
      s6_x1c_r  <= s5_x1c_r;
      s6_t_r    <= s5_t_r;
      s6_dz_r   <= s5_dz_r;
      s6_up_r   <= s5_up_r;
    end
  end

  // Stage 7: B3 before rounding, and X3 of the B4 path.
  logic signed [52:0] s7_x1b;
  logic signed [53:0] s7_x3a;
  logic signed [54:0] s7_b3s;
  logic signed [47:0] s7_x2c;
  logic               s7_v_r;
  logic signed [57:0] s7_b3pre_r;
  logic signed [47:0] s7_x3c_r;
  logic signed [15:0] s7_t_r;
  logic               s7_dz_r;
  logic [18:0]        s7_up_r;

  assign s7_x1b = 53'(s6_b2sq_r >>> 11);
  assign s7_x3a = 54'(s7_x1b) + 54'(s6_x2b_r);
  assign s7_b3s = (55'(ac1) <<< 2) + 55'(s7_x3a);
  assign s7_x2c = 48'(s6_b1sq_r >>> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (pipe_en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s7_b3pre_r <= 58'(s7_b3s) <<< oss_r;
      s7_x3c_r   <= 48'((50'(s6_x1c_r) + 50'(s7_x2c) + 50'sd2) >>> 2);
      s7_t_r     <= s6_t_r;
      s7_dz_r    <= s6_dz_r;
      s7_up_r    <= s6_up_r;
    end
  end

  // Stage 8: UP - B3, and AC4 * (X3 + 32768).
  logic signed [56:0] s8_b3;
  logic               s8_v_r;
  logic signed [57:0] s8_diff_r;
  logic signed [65:0] s8_b4p_r;
  logic signed [15:0] s8_t_r;
  logic               s8_dz_r;

  assign s8_b3 = 57'((59'(s7_b3pre_r) + 59'sd2) >>> 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (pipe_en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s8_diff_r <= $signed({39'b0, s7_up_r}) - 58'(s8_b3);
      s8_b4p_r  <= 66'(ac4) * 66'(49'(s7_x3c_r) + 49'(B4_BIAS));
      s8_t_r    <= s7_t_r;
      s8_dz_r   <= s7_dz_r;
    end
  end

  // Stage 9: B4 and B7.
  logic signed [16:0] s9_scale;
  logic               s9_v_r;
  logic signed [74:0] s9_b7_r;
  logic signed [50:0] s9_b4_r;
  logic signed [15:0] s9_t_r;
  logic               s9_dz_r;

  assign s9_scale = $signed({1'b0, 16'(P_SCALE >> oss_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (pipe_en) begin
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s9_b7_r <= 75'(s8_diff_r) * 75'(s9_scale);
      s9_b4_r <= 51'(s8_b4p_r >>> 15);
      s9_t_r  <= s8_t_r;
      s9_dz_r <= s8_dz_r;
    end
  end

  // Divider 2 operands. B7 below 2^31 and not negative divides as 2*B7,
  // everything else as B7 with the quotient doubled afterwards.
  logic        b7_small;
  logic [74:0] d2_num;
  logic [50:0] d2_den;
  d2_side_t    d2_side_in;
  d2_side_t    d2_side;
  logic [$bits(d2_side_t)-1:0] d2_side_vec;
  logic        d2_valid;
  logic [32:0] d2_quot;
  logic        d2_ovf;

  assign b7_small = (s9_b7_r[74:31] == '0);
  assign d2_num   = b7_small ? {s9_b7_r[73:0], 1'b0}
                  : (s9_b7_r[74] ? 75'(-s9_b7_r) : 75'(s9_b7_r));
  assign d2_den   = s9_b4_r[50] ? 51'(-s9_b4_r) : 51'(s9_b4_r);

  assign d2_side_in.t   = s9_t_r;
  assign d2_side_in.err = s9_dz_r || (s9_b4_r == '0);
  assign d2_side_in.br1 = b7_small;
  assign d2_side_in.neg = s9_b7_r[74] ^ s9_b4_r[50];

  bc_div #(
    .NW(75),
    .DW(51),
    .QW(33),
    .SW($bits(d2_side_t))
  ) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (s9_v_r),
    .num      (d2_num),
    .den      (d2_den),
    .side_in  (d2_side_in),
    .out_valid(d2_valid),
    .quot     (d2_quot),
    .ovf      (d2_ovf),
    .side_out (d2_side_vec)
  );

  assign d2_side = d2_side_t'(d2_side_vec);

  // Stage 11: signed, saturated p.
  logic [34:0]        s11_m;
  logic signed [35:0] s11_ps;
  logic signed [31:0] s11_p;
  logic               s11_v_r;
  logic signed [31:0] s11_p_r;
  logic signed [15:0] s11_t_r;
  logic               s11_err_r;

  assign s11_m  = d2_side.br1 ? 35'(d2_quot) : 35'({d2_quot, 1'b0});
  assign s11_ps = d2_side.neg ? -$signed({1'b0, s11_m}) : $signed({1'b0, s11_m});

  always_comb begin
    if (d2_ovf) begin
      s11_p = d2_side.neg ? 32'sh80000000 : 32'sh7fffffff;
    end else if (s11_ps > 36'sd2147483647) begin
      s11_p = 32'sh7fffffff;
    end else if (s11_ps < -36'sd2147483648) begin
      s11_p = 32'sh80000000;
    end else begin
      s11_p = 32'(s11_ps);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (pipe_en) begin
      s11_v_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s11_p_r   <= s11_p;
      s11_t_r   <= d2_side.t;
      s11_err_r <= d2_side.err;
    end
  end

  // Stage 12: (p >> 8) squared, and -7357 * p.
  logic signed [23:0] s12_a;
  logic               s12_v_r;
  logic signed [47:0] s12_aa_r;
  logic signed [45:0] s12_m2_r;
  logic signed [31:0] s12_p_r;
  logic signed [15:0] s12_t_r;
  logic               s12_err_r;

  assign s12_a = 24'(s11_p_r >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_v_r <= 1'b0;
    end else if (pipe_en) begin
      s12_v_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s12_aa_r  <= 48'(s12_a) * 48'(s12_a);
      s12_m2_r  <= 46'(s11_p_r) * 46'(P_C2);
      s12_p_r   <= s11_p_r;
      s12_t_r   <= s11_t_r;
      s12_err_r <= s11_err_r;
    end
  end

  // Stage 13: 3038 times the square, and X2 truncated toward zero.
  logic signed [45:0] s13_m2adj;
  logic               s13_v_r;
  logic signed [60:0] s13_aa3_r;
  logic signed [29:0] s13_x2_r;
  logic signed [31:0] s13_p_r;
  logic signed [15:0] s13_t_r;
  logic               s13_err_r;

  assign s13_m2adj = s12_m2_r + (s12_m2_r[45] ? 46'sd65535 : 46'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s13_v_r <= 1'b0;
    end else if (pipe_en) begin
      s13_v_r <= s12_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s13_aa3_r <= 61'(s12_aa_r) * 61'(P_C1);
      s13_x2_r  <= 30'(s13_m2adj >>> 16);
      s13_p_r   <= s12_p_r;
      s13_t_r   <= s12_t_r;
      s13_err_r <= s12_err_r;
    end
  end

  // Final correction and clamp of the pressure.
  logic signed [44:0] s14_x1;
  logic signed [45:0] s14_s;
  logic signed [45:0] s14_sadj;
  logic signed [41:0] s14_d;
  logic signed [46:0] s14_pr;
  logic [19:0]        s14_p;

  assign s14_x1   = 45'(s13_aa3_r >>> 16);
  assign s14_s    = 46'(s14_x1) + 46'(s13_x2_r) + 46'(P_C3);
  assign s14_sadj = s14_s + (s14_s[45] ? 46'sd15 : 46'sd0);
  assign s14_d    = 42'(s14_sadj >>> 4);
  assign s14_pr   = 47'(s13_p_r) + 47'(s14_d);

  always_comb begin
    if (s14_pr[46]) begin
      s14_p = '0;
    end else if (s14_pr > 47'sd1048575) begin
      s14_p = 20'hfffff;
    end else begin
      s14_p = 20'(s14_pr);
    end
  end

  // Output register; an error item reports zero values.
  logic               out_valid_r;
  logic signed [15:0] out_t_r;
  logic [19:0]        out_p_r;
  logic               out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s13_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_t_r   <= s13_err_r ? 16'sd0 : s13_t_r;
      out_p_r   <= s13_err_r ? 20'd0 : s14_p;
      out_err_r <= s13_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temp_tenths = out_t_r;
  assign out_pressure_pa = out_p_r;
  assign out_div_error   = out_err_r;

  // An error item carries zero values.
  `BC_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_div_error, out_temp_tenths == 16'sd0 && out_pressure_pa == 20'd0, "error item with nonzero values")
  // The small-B7 branch with a nonzero divisor never overflows the pressure quotient.
  `BC_ASSERT_SAME(a_br1_no_ovf, clk, rst_n, d2_valid && d2_side.br1 && !d2_side.err, !d2_ovf, "pressure quotient overflow on small B7")
  // The temperature quotient never overflows when its divisor is nonzero.
  `BC_ASSERT_SAME(a_t_no_ovf, clk, rst_n, d1_valid && !d1_side.dz, !d1_ovf, "temperature quotient overflow")
  // A held pipeline keeps the stage 13 valid flag unchanged.
  `BC_ASSERT_NEXT(a_hold, clk, rst_n, !pipe_en, s13_v_r == $past(s13_v_r), "pipeline moved while held")

endmodule

// File: tb/barometer_compensation_tb.sv
`timescale 1ns / 100ps

module barometer_compensation_tb;
  import bc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [15:0] temp_tenths;
    logic [19:0]        pressure_pa;
    logic               div_error;
  } reading_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 90;

  // Expected readings and the calibration they are computed from.
  class reading_scoreboard;
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss;
    reading_t    expected_readings[$];

    function new();
      cal_a = '0;
      cal_b = '0;
      cal_c = '0;
      oss   = OSS_RESET;
    endfunction

    function void set_register(cfg_idx_t idx, logic [63:0] data);
      case (idx)
        CFG_CAL_A: cal_a = data;
        CFG_CAL_B: cal_b = data;
        CFG_CAL_C: cal_c = data[31:0];
        CFG_OSS:   oss   = data[1:0];
        default: ;
      endcase
    endfunction

    function wide_t clamp(wide_t x, wide_t lo, wide_t hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Integer compensation of one sample pair, in exact wide arithmetic.
    function reading_t compensate(logic [15:0] raw_t, logic [18:0] raw_p);
      reading_t r;
      wide_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      wide_t x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, pr;
      ac1 = wide_t'($signed(cal_a[63:48]));
      ac2 = wide_t'($signed(cal_a[47:32]));
      ac3 = wide_t'($signed(cal_a[31:16]));
      ac4 = wide_t'(cal_a[15:0]);
      ac5 = wide_t'(cal_b[63:48]);
      ac6 = wide_t'(cal_b[47:32]);
      b1  = wide_t'($signed(cal_b[31:16]));
      b2  = wide_t'($signed(cal_b[15:0]));
      mc  = wide_t'($signed(cal_c[31:16]));
      md  = wide_t'($signed(cal_c[15:0]));
      ut  = wide_t'(raw_t);
      up  = wide_t'(raw_p);
      r.temp_tenths = '0;
      r.pressure_pa = '0;
      r.div_error   = 1'b1;

      // Temperature part; a zero divisor ends the computation.
      x1 = ((ut - ac6) * ac5) >>> 15;
      if (x1 + md == 0) return r;
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;
      t  = clamp((b5 + 8) >>> 4, -32768, 32767);

      // Pressure coefficients.
      b6 = b5 - T_OFFSET;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = (((ac1 * 4 + x3) * (wide_t'(1) <<< oss)) + 2) >>> 2;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      b4 = (ac4 * (x3 + B4_BIAS)) >>> 15;
      if (b4 == 0) return r;

      // Quotient: doubled before dividing only when that cannot overflow.
      b7 = (up - b3) * (wide_t'(P_SCALE) >>> oss);
      if (b7 >= 0 && b7 < (wide_t'(1) <<< 31)) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      p = clamp(p, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);

      // Final correction.
      x1 = p >>> 8;
      x1 = x1 * x1;
      x1 = (x1 * P_C1) >>> 16;
      x2 = (wide_t'(P_C2) * p) / 65536;
      pr = clamp(p + (x1 + x2 + P_C3) / 16, 0, 1048575);

      r.temp_tenths = t[15:0];
      r.pressure_pa = pr[19:0];
      r.div_error   = 1'b0;
      return r;
    endfunction

    function void note_sample(logic [15:0] raw_t, logic [18:0] raw_p);
      expected_readings.push_back(compensate(raw_t, raw_p));
    endfunction

    // Returns one line per mismatching field.
    function void check_reading(reading_t got, ref string errs[$]);
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        errs.push_back("result item arrived with none expected");
        return;
      end
      exp_r = expected_readings.pop_front();
      if (got.temp_tenths !== exp_r.temp_tenths)
        errs.push_back($sformatf("temp_tenths got %0d expected %0d",
                                 got.temp_tenths, exp_r.temp_tenths));
      if (got.pressure_pa !== exp_r.pressure_pa)
        errs.push_back($sformatf("pressure_pa got %0d expected %0d",
                                 got.pressure_pa, exp_r.pressure_pa));
      if (got.div_error !== exp_r.div_error)
        errs.push_back($sformatf("div_error got %0b expected %0b",
                                 got.div_error, exp_r.div_error));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        in_raw_temp;
  logic [18:0]        in_raw_press;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_temp_tenths;
  logic [19:0]        out_pressure_pa;
  logic               out_div_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [63:0]        cfg_data;

  reading_scoreboard sb = new();
  int  mismatches = 0;
  int  hold_request = 0;
  bit  quiet_in = 0;
  bit  quiet_out = 0;

  barometer_compensation DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_temp     (in_raw_temp),
    .in_raw_press    (in_raw_press),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_temp_tenths (out_temp_tenths),
    .out_pressure_pa (out_pressure_pa),
    .out_div_error   (out_div_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Receiver: checks accepted items and draws its stall pattern.
  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    string errs[$];
    reading_t got;
    bit took;
    bit st;
    took = out_valid && !out_stall;
    if (took) begin
      got.temp_tenths = out_temp_tenths;
      got.pressure_pa = out_pressure_pa;
      got.div_error   = out_div_error;
      errs.delete();
      sb.check_reading(got, errs);
      foreach (errs[i]) report(errs[i]);
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else begin
      if (took) stall_left = quiet_out ? 0 : $urandom_range(0, 19);
      else if (stall_left > 0) stall_left--;
      st = (stall_left != 0);
    end
    out_stall <= st;
  end

  // Watchdog on cycles with no handshake on any channel.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_register(cfg_idx_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic calibrate(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
    write_register(CFG_CAL_A, a);
    write_register(CFG_CAL_B, b);
    write_register(CFG_CAL_C, {$urandom(), c});
    write_register(CFG_OSS, {$urandom(), $urandom() & 32'hFFFF_FFFC | o});
  endtask

  task automatic send_sample(logic [15:0] raw_t, logic [18:0] raw_p);
    int gap;
    in_valid     <= 1'b1;
    in_raw_temp  <= raw_t;
    in_raw_press <= raw_p;
    do @(posedge clk); while (in_stall);
    sb.note_sample(raw_t, raw_p);
    gap = quiet_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every in-flight item drain before touching the configuration.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [15:0] mix16(logic [15:0] nominal);
    return ($urandom_range(0, 1) != 0) ? nominal : 16'($urandom());
  endfunction

  // Stimulus.
  initial begin
    logic [63:0] a, b;
    logic [31:0] c;
    logic [15:0] ut;
    logic [18:0] up;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_raw_temp  = '0;
    in_raw_press = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_CAL_A;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: temperature divisor is zero.
    send_sample(16'h0000, 19'h00000);
    send_sample(16'hFFFF, 19'h7FFFF);
    send_sample(16'h6CFA, 19'h05D23);
    drain();

    // Nominal sensor calibration, oversampling 0.
    a = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
    b = {16'd32757, 16'd23153, 16'd6190, 16'd4};
    c = {16'hDDE9, 16'd2868};
    calibrate(a, b, c, 2'd0);
    send_sample(16'd27898, 19'd23843);
    send_sample(16'h0000, 19'h00000);
    send_sample(16'hFFFF, 19'h7FFFF);
    send_sample(16'hFFFF, 19'h00000);
    send_sample(16'h0000, 19'h7FFFF);
    send_sample(16'd23153, 19'd40000);
    drain();
    // Temperature divisor hits zero: X1 + MD = 0 at UT = AC6.
    write_register(CFG_CAL_C, {32'h0, 16'd100, 16'd0});
    send_sample(16'd23153, 19'd23843);
    send_sample(16'd23154, 19'd23843);
    drain();
    // Pressure divisor is zero.
    calibrate({a[63:16], 16'd0}, b, c, 2'd3);
    send_sample(16'd27898, 19'd190000);
    send_sample(16'd30000, 19'd200000);
    drain();
    // Extreme coefficients, negative B4 and wide quotients likely.
    calibrate(64'h8000_8000_8000_FFFF, 64'hFFFF_FFFF_8000_8000, 32'h8000_7FFF, 2'd3);
    send_sample(16'h0000, 19'h7FFFF);
    send_sample(16'hFFFF, 19'h00000);
    send_sample(16'h8000, 19'h40000);
    drain();
    calibrate(64'h7FFF_7FFF_7FFF_FFFF, 64'hFFFF_0000_7FFF_7FFF, 32'h7FFF_8000, 2'd1);
    send_sample(16'h0000, 19'h7FFFF);
    send_sample(16'hFFFF, 19'h00000);
    send_sample(16'h1234, 19'h2AAAA);
    send_sample(16'hFFFF, 19'h7FFFF);
    drain();

    // Random phases with mostly plausible calibration.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = $urandom();
      end else begin
        a = {mix16(16'd408), mix16(16'hFFB8), mix16(16'hC7D1), mix16(16'd32741)};
        b = {mix16(16'd32757), mix16(16'd23153), mix16(16'd6190), mix16(16'd4)};
        c = {mix16(16'hDDE9), mix16(16'd2868)};
      end
      calibrate(a, b, c, 2'($urandom_range(0, 3)));
      quiet_in  = (ph == 1 || ph == 5);
      quiet_out = (ph == 1 || ph == 6);
      for (int i = 0; i < 230; i++) begin
        if (ph == 1 && i == 20) hold_request = 400;
        if (ph == 4 && i == 115) drain();
        if ($urandom_range(0, 1) != 0) begin
          ut = 16'($urandom());
          up = 19'($urandom());
        end else begin
          ut = 16'($urandom_range(20000, 36000));
          up = 19'($urandom_range(10000, 100000) << sb.oss);
        end
        send_sample(ut, up);
      end
      drain();
    end

    if (mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
